/* design/sala_pkg.sv */
// Shared types, codes and helpers of the set-associative LRU tag store.
package sala_pkg;

  localparam int ADDR_W       = 64;
  localparam int TAG_W        = 64;
  localparam int STAMP_W      = 32;
  localparam int CNT_W        = 32;
  localparam int CMD_W        = 2;
  localparam int CFG_W        = 6;
  localparam int CFG_IDX_W    = 2;
  localparam int SET_BITS_W   = 3;
  localparam int BLOCK_BITS_W = 6;
  localparam int WAYS_CFG_W   = 4;

  // Only a modify is special; every other code is a single access.
  localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    logic             hit;
    logic             miss;
    logic             evict;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] evict_total;
    logic             last;
  } res_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

/* design/sala_addr_split.sv */
// Splits a byte address into set index and tag under the current geometry.
module sala_addr_split #(
  parameter int MAX_SET_BITS = 6,
  parameter int SET_W        = 6
) (
  input  logic [sala_pkg::ADDR_W-1:0]       address_i,
  input  logic [sala_pkg::SET_BITS_W-1:0]   set_bits_i,
  input  logic [sala_pkg::BLOCK_BITS_W-1:0] block_bits_i,
  output logic [SET_W-1:0]                  set_o,
  output logic [sala_pkg::TAG_W-1:0]        tag_o
);

  localparam int SB_W  = $clog2(MAX_SET_BITS + 1) + 1;
  localparam int MSK_W = SET_W + 1;
  localparam int SH_W  = sala_pkg::BLOCK_BITS_W + 1;

  logic [SB_W-1:0]             sb;
  logic [sala_pkg::ADDR_W-1:0] set_src;
  logic [MSK_W-1:0]            mask;
  logic [SH_W-1:0]             tag_shift;

  always_comb begin
    if (SB_W'(set_bits_i) > SB_W'(MAX_SET_BITS)) begin
      sb = SB_W'(MAX_SET_BITS);
    end else begin
      sb = SB_W'(set_bits_i);
    end
    set_src   = address_i >> block_bits_i;
    mask      = (MSK_W'(1) << sb) - MSK_W'(1);
    set_o     = set_src[SET_W-1:0] & mask[SET_W-1:0];
    tag_shift = SH_W'(block_bits_i) + SH_W'(sb);
    // A shift of 64 or more leaves nothing of the address.
    if (tag_shift >= SH_W'(sala_pkg::ADDR_W)) begin
      tag_o = '0;
    end else begin
      tag_o = address_i >> tag_shift[SH_W-2:0];
    end
  end

endmodule

/* design/sala_set_store.sv */
// Per-set line state and tag memories, one set row per address, with a registered read.
module sala_set_store #(
  parameter int SET_COUNT = 64,
  parameter int SET_W     = 6,
  parameter int WAYS      = 8,
  parameter int WAY_W     = 3
) (
  input  logic                                     clk_i,
  input  logic                                     rd_en_i,
  input  logic [SET_W-1:0]                         rd_addr_i,
  input  logic                                     st_we_i,
  input  logic [SET_W-1:0]                         wr_addr_i,
  input  logic [WAYS-1:0]                          wr_valid_i,
  input  logic [WAYS-1:0][sala_pkg::STAMP_W-1:0]   wr_stamp_i,
  input  logic [sala_pkg::STAMP_W-1:0]             wr_timer_i,
  input  logic                                     tag_we_i,
  input  logic [WAY_W-1:0]                         tag_way_i,
  input  logic [sala_pkg::TAG_W-1:0]               tag_i,
  output logic [WAYS-1:0]                          rd_valid_o,
  output logic [WAYS-1:0][sala_pkg::STAMP_W-1:0]   rd_stamp_o,
  output logic [sala_pkg::STAMP_W-1:0]             rd_timer_o,
  output logic [WAYS-1:0][sala_pkg::TAG_W-1:0]     rd_tag_o
);

  localparam int ROW_W = WAYS + WAYS * sala_pkg::STAMP_W + sala_pkg::STAMP_W;

  logic [ROW_W-1:0]                     st_mem  [SET_COUNT];
  logic [WAYS-1:0][sala_pkg::TAG_W-1:0] tag_mem [SET_COUNT];

  always_ff @(posedge clk_i) begin
    if (st_we_i) begin
      st_mem[wr_addr_i] <= {wr_timer_i, wr_stamp_i, wr_valid_i};
    end
    if (rd_en_i) begin
      {rd_timer_o, rd_stamp_o, rd_valid_o} <= st_mem[rd_addr_i];
    end
  end

  // Tags are written one way at a time and are never cleared.
  always_ff @(posedge clk_i) begin
    if (tag_we_i) begin
      tag_mem[wr_addr_i][tag_way_i] <= tag_i;
    end
    if (rd_en_i) begin
      rd_tag_o <= tag_mem[rd_addr_i];
    end
  end

endmodule

/* design/sala_lookup.sv */
// Tag match, empty-way search and line ages over one set row.
module sala_lookup #(
  parameter int WAYS  = 8,
  parameter int WAY_W = 3
) (
  input  logic [WAYS-1:0]                        in_use_i,
  input  logic [sala_pkg::TAG_W-1:0]             tag_i,
  input  logic [WAYS-1:0]                        rd_valid_i,
  input  logic [WAYS-1:0][sala_pkg::STAMP_W-1:0] rd_stamp_i,
  input  logic [WAYS-1:0][sala_pkg::TAG_W-1:0]   rd_tag_i,
  input  logic [sala_pkg::STAMP_W-1:0]           new_stamp_i,
  output logic                                   hit_any_o,
  output logic [WAY_W-1:0]                       hit_way_o,
  output logic                                   empty_any_o,
  output logic [WAY_W-1:0]                       empty_way_o,
  output logic [WAYS-1:0]                        cand_o,
  output logic [WAYS-1:0][sala_pkg::STAMP_W-1:0] age_o
);

  logic [WAYS-1:0] hit_vec;
  logic [WAYS-1:0] empty_vec;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      cand_o[w]    = in_use_i[w] & rd_valid_i[w];
      hit_vec[w]   = cand_o[w] & (rd_tag_i[w] == tag_i);
      empty_vec[w] = in_use_i[w] & ~rd_valid_i[w];
      age_o[w]     = new_stamp_i - rd_stamp_i[w];
    end
    hit_any_o   = |hit_vec;
    empty_any_o = |empty_vec;
    // Walk down so that the lowest matching way wins.
    hit_way_o   = '0;
    empty_way_o = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way_o = WAY_W'(w);
      end
      if (empty_vec[w]) begin
        empty_way_o = WAY_W'(w);
      end
    end
  end

endmodule

/* design/set_assoc_lru_cache_tags_core.sv */
// Top level of the set-associative tag store with true LRU replacement.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------
//   request  | start, busy            | req_i (cmd, address)
//   result   | res_valid_o strobe     | res_o (hit ... last)
//   config   | cfg_we_i, cfg_idx_i    | cfg_wdata_i
//
// A load or store runs from accept to the next accept in steps: the set row
// read from memory, then the tag match and ages, then the victim search and
// write-back. A modify runs the access twice, rereading the set row between.
// Each result shows for one cycle right after its write-back cycle; the
// receiver cannot stall. After reset a clearing pass over all SET_COUNT sets
// (64 sets by default) zeroes valid bits, stamps and timers while busy is high.
module set_assoc_lru_cache_tags_core #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  sala_pkg::req_t                     req_i,
  output logic                               res_valid_o,
  output sala_pkg::res_t                     res_o,
  input  logic                               cfg_we_i,
  input  logic [sala_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sala_pkg::CFG_W-1:0]         cfg_wdata_i
);

  localparam int SET_COUNT = 1 << MAX_SET_BITS;
  localparam int SET_W     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WC_W      = sala_pkg::WAYS_CFG_W + 1;
  localparam int STAMP_W   = sala_pkg::STAMP_W;
  localparam int CNT_W     = sala_pkg::CNT_W;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_LOOKUP = 3'd2;
  localparam logic [2:0] ST_UPDATE = 3'd3;
  localparam logic [2:0] ST_REREAD = 3'd4;

  logic [2:0] state_q, state_d;
  logic [SET_W-1:0] clr_q, clr_d;
  logic accept;

  logic [sala_pkg::SET_BITS_W-1:0]   set_bits_q;
  logic [sala_pkg::BLOCK_BITS_W-1:0] block_bits_q;
  logic [sala_pkg::WAYS_CFG_W-1:0]   ways_q;

  logic [SET_W-1:0]             split_set;
  logic [sala_pkg::TAG_W-1:0]   split_tag;
  logic [SET_W-1:0]             set_q;
  logic [sala_pkg::TAG_W-1:0]   tag_q;
  logic                         modify_q;
  logic                         second_q;

  logic [MAX_WAYS-1:0] in_use;

  logic                                    rd_en;
  logic [SET_W-1:0]                        rd_addr;
  logic                                    st_we;
  logic [MAX_WAYS-1:0]                     wr_valid;
  logic [MAX_WAYS-1:0][STAMP_W-1:0]        wr_stamp;
  logic [STAMP_W-1:0]                      wr_timer;
  logic                                    tag_we;
  logic [MAX_WAYS-1:0]                     rd_valid;
  logic [MAX_WAYS-1:0][STAMP_W-1:0]        rd_stamp;
  logic [STAMP_W-1:0]                      rd_timer;
  logic [MAX_WAYS-1:0][sala_pkg::TAG_W-1:0] rd_tag;
  logic [STAMP_W-1:0]                      new_stamp;

  logic                             lk_hit_any, lk_empty_any;
  logic [WAY_W-1:0]                 lk_hit_way, lk_empty_way;
  logic [MAX_WAYS-1:0]              lk_cand;
  logic [MAX_WAYS-1:0][STAMP_W-1:0] lk_age;

  logic                             hit_any_q, empty_any_q;
  logic [WAY_W-1:0]                 hit_way_q, empty_way_q;
  logic [MAX_WAYS-1:0]              cand_q;
  logic [MAX_WAYS-1:0][STAMP_W-1:0] age_q;

  logic [WAY_W-1:0]   victim;
  logic [STAMP_W-1:0] best_age;
  logic [WAY_W-1:0]   slot;

  logic [CNT_W-1:0] hit_cnt_q, hit_cnt_d;
  logic [CNT_W-1:0] miss_cnt_q, miss_cnt_d;
  logic [CNT_W-1:0] evict_cnt_q, evict_cnt_d;

  sala_pkg::res_t res_q, res_d;
  logic           res_valid_q;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start & ~busy;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= '0;
      block_bits_q <= '0;
      ways_q       <= sala_pkg::WAYS_CFG_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sala_pkg::CFG_SET_BITS:   set_bits_q   <= cfg_wdata_i[sala_pkg::SET_BITS_W-1:0];
        sala_pkg::CFG_BLOCK_BITS: block_bits_q <= cfg_wdata_i[sala_pkg::BLOCK_BITS_W-1:0];
        sala_pkg::CFG_WAYS:       ways_q       <= cfg_wdata_i[sala_pkg::WAYS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // A way count of zero still uses way 0; counts above the array use all ways.
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w] = (w == 0) || (WC_W'(ways_q) > WC_W'(w));
    end
  end

  sala_addr_split #(
    .MAX_SET_BITS(MAX_SET_BITS),
    .SET_W       (SET_W)
  ) u_split (
    .address_i   (req_i.address),
    .set_bits_i  (set_bits_q),
    .block_bits_i(block_bits_q),
    .set_o       (split_set),
    .tag_o       (split_tag)
  );

  assign rd_en   = accept | (state_q == ST_REREAD);
  assign rd_addr = accept ? split_set : set_q;

  sala_set_store #(
    .SET_COUNT(SET_COUNT),
    .SET_W    (SET_W),
    .WAYS     (MAX_WAYS),
    .WAY_W    (WAY_W)
  ) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .st_we_i   (st_we),
    .wr_addr_i ((state_q == ST_CLEAR) ? clr_q : set_q),
    .wr_valid_i(wr_valid),
    .wr_stamp_i(wr_stamp),
    .wr_timer_i(wr_timer),
    .tag_we_i  (tag_we),
    .tag_way_i (slot),
    .tag_i     (tag_q),
    .rd_valid_o(rd_valid),
    .rd_stamp_o(rd_stamp),
    .rd_timer_o(rd_timer),
    .rd_tag_o  (rd_tag)
  );

  // The read data holds until the next read, so it serves both later stages.
  assign new_stamp = rd_timer + STAMP_W'(1);

  sala_lookup #(
    .WAYS (MAX_WAYS),
    .WAY_W(WAY_W)
  ) u_lookup (
    .in_use_i   (in_use),
    .tag_i      (tag_q),
    .rd_valid_i (rd_valid),
    .rd_stamp_i (rd_stamp),
    .rd_tag_i   (rd_tag),
    .new_stamp_i(new_stamp),
    .hit_any_o  (lk_hit_any),
    .hit_way_o  (lk_hit_way),
    .empty_any_o(lk_empty_any),
    .empty_way_o(lk_empty_way),
    .cand_o     (lk_cand),
    .age_o      (lk_age)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOOKUP) begin
      hit_any_q   <= lk_hit_any;
      hit_way_q   <= lk_hit_way;
      empty_any_q <= lk_empty_any;
      empty_way_q <= lk_empty_way;
      cand_q      <= lk_cand;
      age_q       <= lk_age;
    end
    if (accept) begin
      set_q    <= split_set;
      tag_q    <= split_tag;
      modify_q <= (req_i.cmd == sala_pkg::CMD_MODIFY);
    end
  end

  // Oldest valid way; a tie keeps the lower way. Only used when the set is full.
  always_comb begin
    victim   = '0;
    best_age = age_q[0];
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (cand_q[w] && (age_q[w] > best_age)) begin
        best_age = age_q[w];
        victim   = WAY_W'(w);
      end
    end
    if (hit_any_q) begin
      slot = hit_way_q;
    end else if (empty_any_q) begin
      slot = empty_way_q;
    end else begin
      slot = victim;
    end
  end

  always_comb begin
    st_we  = (state_q == ST_CLEAR) || (state_q == ST_UPDATE);
    tag_we = (state_q == ST_UPDATE) && !hit_any_q;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (state_q == ST_CLEAR) begin
        wr_valid[w] = 1'b0;
        wr_stamp[w] = '0;
      end else if (WAY_W'(w) == slot) begin
        wr_valid[w] = 1'b1;
        wr_stamp[w] = new_stamp;
      end else begin
        wr_valid[w] = rd_valid[w];
        wr_stamp[w] = rd_stamp[w];
      end
    end
    wr_timer = (state_q == ST_CLEAR) ? '0 : new_stamp;
  end

  // Counters and the result of the write-back cycle.
  always_comb begin
    hit_cnt_d   = hit_cnt_q;
    miss_cnt_d  = miss_cnt_q;
    evict_cnt_d = evict_cnt_q;
    if (state_q == ST_UPDATE) begin
      if (hit_any_q) begin
        hit_cnt_d = sala_pkg::sat_inc(hit_cnt_q);
      end else begin
        miss_cnt_d = sala_pkg::sat_inc(miss_cnt_q);
        if (!empty_any_q) begin
          evict_cnt_d = sala_pkg::sat_inc(evict_cnt_q);
        end
      end
    end
    res_d.hit         = hit_any_q;
    res_d.miss        = !hit_any_q;
    res_d.evict       = !hit_any_q && !empty_any_q;
    res_d.hit_total   = hit_cnt_d;
    res_d.miss_total  = miss_cnt_d;
    res_d.evict_total = evict_cnt_d;
    res_d.last        = !(modify_q && !second_q);
  end

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + SET_W'(1);
        if (clr_q == SET_W'(SET_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: state_d = ST_UPDATE;
      ST_UPDATE: begin
        if (modify_q && !second_q) begin
          state_d = ST_REREAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_REREAD: state_d = ST_LOOKUP;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      second_q    <= 1'b0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      evict_cnt_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      hit_cnt_q   <= hit_cnt_d;
      miss_cnt_q  <= miss_cnt_d;
      evict_cnt_q <= evict_cnt_d;
      res_valid_q <= (state_q == ST_UPDATE);
      if (accept) begin
        second_q <= 1'b0;
      end else if (state_q == ST_UPDATE) begin
        second_q <= modify_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_UPDATE) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // An eviction only ever comes with a miss.
  a_evict_is_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.evict |-> res_q.miss)
    else $error("eviction reported without a miss");

  // The second access of a modify finds the line that the first one left.
  a_modify_second_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_q.last |-> ##3 (res_valid_q && res_q.hit && res_q.last))
    else $error("second access of a modify did not hit");

  // A result strobe follows a write-back cycle and nothing else.
  a_res_after_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> $past(state_q) == ST_UPDATE)
    else $error("result strobe without a write-back cycle");

  // No new transaction is taken while the clearing pass runs.
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |=> state_q == ST_CLEAR || state_q == ST_IDLE)
    else $error("clearing pass left for a busy state");

endmodule
